/* src/insertion_sorter_unit_macros.svh */
// Assertion macros for the insertion sorter checker.
// Included by files that assert; depends on nothing else.
`ifndef INSERTION_SORTER_UNIT_MACROS_SVH
`define INSERTION_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define INS_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("insertion sorter check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define INS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("insertion sorter check failed");

`endif

/* src/ins_sort_pkg.sv */
// Shared types for the insertion sorter.
// No dependencies; imported by the interfaces, the cell, the top level and the checker.
`timescale 1ns / 1ps

package ins_sort_pkg;

   typedef logic signed [31:0] element_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

/* src/ins_sort_if.sv */
// Request and result channel interfaces of the insertion sorter.
// Depends on ins_sort_pkg for the element type.
`timescale 1ns / 1ps

interface ins_req_if import ins_sort_pkg::*; ();
   logic        valid;
   logic        ready;
   element_type value;
   logic        is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink (input valid, input value, input is_last, output ready);
endinterface

interface ins_rsp_if import ins_sort_pkg::*; ();
   logic        valid;
   logic        ready;
   element_type sorted_value;
   logic        end_of_set;
   logic        overflow;

   modport source (output valid, output sorted_value, output end_of_set, output overflow,
                   input ready);
   modport sink (input valid, input sorted_value, input end_of_set, input overflow,
                 output ready);
endinterface

/* src/ins_sort_cell.sv */
// One cell of the insertion chain: holds a single stored value.
// Depends on ins_sort_pkg for the element and control types.
`timescale 1ns / 1ps

module ins_sort_cell import ins_sort_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  element_type   new_value,
   input  element_type   prev_value,
   input  logic          prev_gt,
   input  element_type   next_value,
   output element_type   value,
   output logic          gt
);

   element_type value_ff;
   element_type value_in;

   // Empty cells count as greater so the new value lands at the fill point.
   assign gt = !occupied || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (prev_gt) begin
            value_in = prev_value;
         end else if (gt) begin
            value_in = new_value;
         end
      end else if (ctrl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* src/insertion_sorter_unit.sv */
// Insertion sorter: one request per cycle while a set is filling; the last request
// starts emission of the whole set, one result per cycle while results are taken,
// smallest first. The last request sets the emission state; each result is then
// shifted out of the chain through cell zero into the registered output.
// Requests are held off during emission. Synchronous active-high reset clears the
// fill count, drop flag, emission state and result valid; stored values are not reset.
`timescale 1ns / 1ps

module insertion_sorter_unit import ins_sort_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   ins_req_if.sink     req_bus,
   ins_rsp_if.source   rsp_bus
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             dropped_ff, dropped_in;
   logic             emit_ff, emit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   element_type      rsp_value_ff;
   logic             rsp_end_ff;
   logic             rsp_ovf_ff;

   logic             req_accept;
   logic             room;
   logic             load;
   cell_ctrl_type    ctrl;

   element_type      cell_value [DEPTH];
   logic             cell_gt    [DEPTH];
   logic             cell_occ   [DEPTH];

   // Accept requests only while filling; emission owns the chain.
   assign req_bus.ready = !emit_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign room          = fill_ff < CNT_W'(DEPTH);

   // In emission, load a result when the output register is free or being drained.
   assign load = emit_ff && (!rsp_valid_ff || rsp_bus.ready);

   assign ctrl.insert = req_accept && room;
   assign ctrl.shift  = load;

   // Chain of cells, compared against the incoming value in parallel. On insert each
   // takes a greater left neighbor, else the new value if greater; right on shift-out.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occ[i] = fill_ff > CNT_W'(i);

      if (i == 0) begin : g_head
         ins_sort_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_value  (req_bus.value),
            .prev_value (req_bus.value),
            .prev_gt    (1'b0),
            .next_value (cell_value[(i + 1) % DEPTH]),
            .value      (cell_value[i]),
            .gt         (cell_gt[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         // Tail has no right neighbor; its value after shift-out is unused.
         ins_sort_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_value  (req_bus.value),
            .prev_value (cell_value[i - 1]),
            .prev_gt    (cell_gt[i - 1]),
            .next_value (cell_value[i]),
            .value      (cell_value[i]),
            .gt         (cell_gt[i])
         );
      end else begin : g_mid
         ins_sort_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .new_value  (req_bus.value),
            .prev_value (cell_value[i - 1]),
            .prev_gt    (cell_gt[i - 1]),
            .next_value (cell_value[i + 1]),
            .value      (cell_value[i]),
            .gt         (cell_gt[i])
         );
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      emit_in    = emit_ff;
      if (req_accept) begin
         // Store if there is room, otherwise drop and flag the set.
         if (room) begin
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
         if (req_bus.is_last) begin
            emit_in = 1'b1;
         end
      end
      if (load) begin
         fill_in = fill_ff - CNT_W'(1);
         // Final value of the set: leave emission and clear the flag.
         if (fill_ff == CNT_W'(1)) begin
            emit_in    = 1'b0;
            dropped_in = 1'b0;
         end
      end
   end

   // Hold the result until taken; advance on load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff <= cell_value[0];
         rsp_end_ff   <= (fill_ff == CNT_W'(1));
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sorted_value = rsp_value_ff;
   assign rsp_bus.end_of_set   = rsp_end_ff;
   assign rsp_bus.overflow     = rsp_ovf_ff;

endmodule

/* src/ins_sort_checker.sv */
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on ins_sort_pkg and insertion_sorter_unit_macros.svh.
`timescale 1ns / 1ps
`include "insertion_sorter_unit_macros.svh"

module ins_sort_checker import ins_sort_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input element_type rsp_sorted_value,
   input logic        rsp_end_of_set,
   input logic        rsp_overflow
);

   logic        rsp_stall;
   logic        last_accept;
   logic        mid_result;
   logic        mid_take;
   logic [33:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign last_accept = req_valid && req_ready && req_is_last;
   assign mid_result  = rsp_valid && !rsp_end_of_set;
   assign mid_take    = rsp_valid && rsp_ready && !rsp_end_of_set;
   assign rsp_payload = {rsp_sorted_value, rsp_end_of_set, rsp_overflow};

   // Stalled result holds its payload.
   `INS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // End of a set stops requests for the emission.
   `INS_ASSERT_NEXT(a_last_blocks, clock, reset, last_accept, !req_ready)

   // A result that is not the final one means emission is still running.
   `INS_ASSERT_NOW(a_mid_blocks, clock, reset, mid_result, !req_ready)

   // Overflow stays the same from one result to the next within a set.
   `INS_ASSERT_NEXT(a_ovf_steady, clock, reset, mid_take, !rsp_valid || $stable(rsp_overflow))

endmodule

bind insertion_sorter_unit ins_sort_checker u_ins_sort_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_is_last      (req_bus.is_last),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_sorted_value (rsp_bus.sorted_value),
   .rsp_end_of_set   (rsp_bus.end_of_set),
   .rsp_overflow     (rsp_bus.overflow)
);
